[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands shared by the blur RTL. Each macro
// expects clk_i and the active-low reset rst_ni to be in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_PROP(label, !(cond), msg)

`endif

[sv/bblur_pkg.sv]
// ----------------------------------------------------------------------------
// bblur_pkg
// Types, widths and arithmetic helpers for the 3x3 edge-aware box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

  // Default line-buffer depth (largest image side)
  localparam int MAX_SIDE_DEF = 32;

  localparam int CH_W        = 16;
  localparam int SIDE_W      = 6;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd32;
  // One column of up to three pixels, and up to three columns
  localparam int COL_W       = 18;
  localparam int SUM_W       = 20;
  localparam int NUM_W       = 4;
  // Reciprocal multiply: floor(x / d) = (x * ceil(2^23 / d)) >> 23 for x < 2^20
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 23;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } colsum_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

  // One neighbourhood sum on its way to the divider
  typedef struct packed {
    sum_t             sum;
    logic [NUM_W-1:0] num;
    logic             last;
  } acc_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LAST,
    S_FLOAD,
    S_FLUSH
  } state_e;

  // Sum one window column, each of the three pixels gated by its enable
  function automatic colsum_t col_sum(pixel_t top, logic use_top, pixel_t mid, logic use_mid,
                                      pixel_t bot, logic use_bot);
    colsum_t s;
    s.red   = (use_top ? COL_W'(top.red)   : '0) + (use_mid ? COL_W'(mid.red)   : '0)
            + (use_bot ? COL_W'(bot.red)   : '0);
    s.green = (use_top ? COL_W'(top.green) : '0) + (use_mid ? COL_W'(mid.green) : '0)
            + (use_bot ? COL_W'(bot.green) : '0);
    s.blue  = (use_top ? COL_W'(top.blue)  : '0) + (use_mid ? COL_W'(mid.blue)  : '0)
            + (use_bot ? COL_W'(bot.blue)  : '0);
    return s;
  endfunction

  // Sum up to three column sums, each gated by its enable
  function automatic sum_t add_cols(colsum_t x, logic use_x, colsum_t y, logic use_y,
                                    colsum_t z, logic use_z);
    sum_t s;
    s.red   = (use_x ? SUM_W'(x.red)   : '0) + (use_y ? SUM_W'(y.red)   : '0)
            + (use_z ? SUM_W'(z.red)   : '0);
    s.green = (use_x ? SUM_W'(x.green) : '0) + (use_y ? SUM_W'(y.green) : '0)
            + (use_z ? SUM_W'(z.green) : '0);
    s.blue  = (use_x ? SUM_W'(x.blue)  : '0) + (use_y ? SUM_W'(y.blue)  : '0)
            + (use_z ? SUM_W'(z.blue)  : '0);
    return s;
  endfunction

  // Number of pixels in a rows x cols neighbourhood
  function automatic logic [NUM_W-1:0] cell_count(logic [1:0] rows, logic [1:0] cols);
    return NUM_W'(rows) * NUM_W'(cols);
  endfunction

  // ceil(2^23 / num); a count of zero or above nine divides by one
  function automatic logic [RECIP_W-1:0] recip_of(logic [NUM_W-1:0] num);
    logic [RECIP_W-1:0] m;
    case (num)
      4'd2:    m = 24'd4194304;
      4'd3:    m = 24'd2796203;
      4'd4:    m = 24'd2097152;
      4'd5:    m = 24'd1677722;
      4'd6:    m = 24'd1398102;
      4'd7:    m = 24'd1198373;
      4'd8:    m = 24'd1048576;
      4'd9:    m = 24'd932068;
      default: m = 24'd8388608;
    endcase
    return m;
  endfunction

endpackage

[sv/bblur_ram.sv]
// ----------------------------------------------------------------------------
// bblur_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bblur_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bblur_mean.sv]
// ----------------------------------------------------------------------------
// bblur_mean
// Sum register, reciprocal-multiply divider and output register for results.
// ----------------------------------------------------------------------------
module bblur_mean (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_valid_i,
  input  bblur_pkg::acc_t             acc_i,
  output logic                        acc_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bblur_pkg::CH_W-1:0]  out_red_o,
  output logic [bblur_pkg::CH_W-1:0]  out_green_o,
  output logic [bblur_pkg::CH_W-1:0]  out_blue_o,
  output logic                        frame_end_o
);

  import bblur_pkg::*;

  `include "assert_macros.svh"

  localparam int PROD_W = SUM_W + RECIP_W;

  logic              sum_valid_q;
  acc_t              sum_q;
  logic              out_valid_q;
  logic [CH_W-1:0]   red_q;
  logic [CH_W-1:0]   green_q;
  logic [CH_W-1:0]   blue_q;
  logic              last_q;
  logic              advance;
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0] prod_red;
  logic [PROD_W-1:0] prod_green;
  logic [PROD_W-1:0] prod_blue;

  // Quotient check: q * num <= sum < (q + 1) * num
  function automatic logic q_ok(logic [SUM_W-1:0] sum, logic [CH_W-1:0] q,
                                logic [NUM_W-1:0] num);
    logic [SUM_W-1:0] lo;
    lo = SUM_W'(q) * SUM_W'(num);
    return (lo <= sum) && ((sum - lo) < SUM_W'(num));
  endfunction

  // Advance when the output register is empty or being taken
  assign advance     = !out_valid_q || !out_stall_i;
  assign acc_ready_o = !sum_valid_q || advance;

  // Divide by the neighbour count through its reciprocal
  assign recip      = recip_of(sum_q.num);
  assign prod_red   = PROD_W'(sum_q.sum.red)   * PROD_W'(recip);
  assign prod_green = PROD_W'(sum_q.sum.green) * PROD_W'(recip);
  assign prod_blue  = PROD_W'(sum_q.sum.blue)  * PROD_W'(recip);

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= sum_valid_q;
      end
      if (acc_ready_o) begin
        sum_valid_q <= acc_valid_i;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (acc_ready_o && acc_valid_i) begin
      sum_q <= acc_i;
    end
    if (advance && sum_valid_q) begin
      red_q   <= prod_red[RECIP_SHIFT +: CH_W];
      green_q <= prod_green[RECIP_SHIFT +: CH_W];
      blue_q  <= prod_blue[RECIP_SHIFT +: CH_W];
      last_q  <= sum_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign frame_end_o = last_q;

  `ASSERT_PROP(a_quotient_exact, (advance && sum_valid_q) |=> (q_ok($past(sum_q.sum.red), out_red_o, $past(sum_q.num)) && q_ok($past(sum_q.sum.green), out_green_o, $past(sum_q.num)) && q_ok($past(sum_q.sum.blue), out_blue_o, $past(sum_q.num))), "divider quotient off")

endmodule

[sv/box_blur_3x3_edge_aware_core.sv]
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core
// 3x3 mean of a square RGB image, clipped at the border, over line buffers.
// ----------------------------------------------------------------------------
// Usage:
//   Input items are pixels in raster order on in_valid_i / in_stall_o; results
//   leave in raster order on out_valid_o / out_stall_i, frame_end_o set on the
//   last one. cfg_wen_i writes the image side (0 acts as 1, above MAX_SIDE
//   acts as MAX_SIDE) and restarts the frame; write it only while idle.
//   The accept cycle reads both line buffers at the pixel's column; S_READ
//   then forms at most one result from the window and writes the column
//   back. A result passes the sum register and then the output register
//   after the item that completes its neighbourhood is accepted, i.e. one
//   row plus one pixel behind its own pixel. The last pixel of a frame
//   also produces the lower-right result of the second-last row and then
//   sweeps the line buffers, one column a cycle while results are taken,
//   giving the whole last row before the next item is taken.
//   Reset sets the side to 32 and the position to the frame start; the line
//   buffers are not cleared, entries outside the current frame are masked.
//   When the receiver stalls, the output register and one sum register hold
//   results, then the sequencer waits and in_stall_o stays high.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_core #(
  parameter int MAX_SIDE = bblur_pkg::MAX_SIDE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_wen_i,
  input  logic [bblur_pkg::SIDE_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bblur_pkg::CH_W-1:0]   in_red_i,
  input  logic [bblur_pkg::CH_W-1:0]   in_green_i,
  input  logic [bblur_pkg::CH_W-1:0]   in_blue_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bblur_pkg::CH_W-1:0]   out_red_o,
  output logic [bblur_pkg::CH_W-1:0]   out_green_o,
  output logic [bblur_pkg::CH_W-1:0]   out_blue_o,
  output logic                         frame_end_o
);

  import bblur_pkg::*;

  `include "assert_macros.svh"

  localparam int CW = $clog2(MAX_SIDE + 1);
  localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  state_e            state_q, state_d;
  logic [SIDE_W-1:0] image_side_q;
  logic [CW-1:0]     side_n;
  logic [CW-1:0]     side_m1;
  logic              two_rows;

  logic [CW-1:0]     row_q, col_q;
  logic [CW-1:0]     r_in, c_in, row_d, col_d;
  logic              last_in;
  logic              accept;

  logic [CW-1:0]     item_row_q, item_col_q;
  logic              item_last_q;
  pixel_t            px_q;
  pixel_t            px_in;

  // Last two window columns; rows 0..2 = two rows up, one row up, current row
  pixel_t            win_a_q [3];
  pixel_t            win_b_q [3];

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr, ram_waddr;
  pixel_t            up_rd, mid_rd;
  logic [$bits(pixel_t)-1:0] up_rdata, mid_rdata;

  logic              acc_valid, acc_ready, step_go;
  acc_t              acc, read_acc, last_acc, flush_acc;

  colsum_t           cs_a, cs_b, cs_c, cs_la, cs_lb, cs_rd;
  logic              read_c0, read_emit, read_top, read_use_a;
  logic              last_top;

  logic [CW-1:0]     flush_col_q;
  logic [CW:0]       j_p2;
  logic              has_next, has_prev;
  colsum_t           fl_prev_q, fl_cur_q;

  // Effective side length
  always_comb begin
    if (image_side_q == '0) begin
      side_n = CW'(1);
    end else if (image_side_q > SIDE_W'(MAX_SIDE)) begin
      side_n = CW'(MAX_SIDE);
    end else begin
      side_n = CW'(image_side_q);
    end
  end
  assign side_m1  = side_n - CW'(1);
  assign two_rows = (side_n != CW'(1));

  // Position of the incoming pixel and of the next one
  always_comb begin
    if ((row_q >= side_n) || (col_q >= side_n)) begin
      r_in = '0;
      c_in = '0;
    end else begin
      r_in = row_q;
      c_in = col_q;
    end
    last_in = (r_in == side_m1) && (c_in == side_m1);
    if (last_in) begin
      row_d = '0;
      col_d = '0;
    end else if (c_in == side_m1) begin
      row_d = r_in + CW'(1);
      col_d = '0;
    end else begin
      row_d = r_in;
      col_d = c_in + CW'(1);
    end
  end

  assign accept = in_valid_i && !in_stall_o;
  assign px_in  = '{red: in_red_i, green: in_green_i, blue: in_blue_i};

  // Line buffers: upper holds two rows up, middle one row up
  bblur_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (MAX_SIDE)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (mid_rd),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (up_rdata)
  );

  bblur_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (MAX_SIDE)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (px_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (mid_rdata)
  );

  assign up_rd     = pixel_t'(up_rdata);
  assign mid_rd    = pixel_t'(mid_rdata);
  assign ram_waddr = item_col_q[AW-1:0];

  // Window result for a pixel step: row-end pixel at column 0, else the one up-left
  assign read_c0    = (item_col_q == '0);
  assign read_emit  = read_c0 ? (int'(item_row_q) >= 2) : (int'(item_row_q) >= 1);
  assign read_top   = read_c0 ? (int'(item_row_q) >= 3) : (int'(item_row_q) >= 2);
  assign read_use_a = read_c0 || (int'(item_col_q) >= 2);
  assign cs_a = col_sum(win_a_q[0], read_top, win_a_q[1], 1'b1, win_a_q[2], 1'b1);
  assign cs_b = col_sum(win_b_q[0], read_top, win_b_q[1], 1'b1, win_b_q[2], 1'b1);
  assign cs_c = col_sum(up_rd, read_top, mid_rd, 1'b1, px_q, 1'b1);

  always_comb begin
    read_acc.sum  = add_cols(cs_a, read_use_a, cs_b, 1'b1, cs_c, !read_c0);
    read_acc.num  = cell_count(read_top ? 2'd3 : 2'd2,
                               (read_use_a && !read_c0) ? 2'd3 : 2'd2);
    read_acc.last = 1'b0;
  end

  // Lower-right result of the second-last row, from the shifted window
  assign last_top = (int'(item_row_q) >= 2);
  assign cs_la = col_sum(win_a_q[0], last_top, win_a_q[1], 1'b1, win_a_q[2], 1'b1);
  assign cs_lb = col_sum(win_b_q[0], last_top, win_b_q[1], 1'b1, win_b_q[2], 1'b1);

  always_comb begin
    last_acc.sum  = add_cols(cs_la, 1'b1, cs_lb, 1'b1, '0, 1'b0);
    last_acc.num  = cell_count(last_top ? 2'd3 : 2'd2, 2'd2);
    last_acc.last = 1'b0;
  end

  // Last-row sweep over the line buffers, one column a step
  assign has_prev = (flush_col_q != '0);
  assign has_next = (flush_col_q != side_m1);
  assign j_p2     = {1'b0, flush_col_q} + (CW+1)'(2);
  assign cs_rd    = col_sum(up_rd, two_rows, mid_rd, 1'b1, '0, 1'b0);

  always_comb begin
    flush_acc.sum  = add_cols(fl_prev_q, has_prev, fl_cur_q, 1'b1, cs_rd, has_next);
    flush_acc.num  = cell_count(two_rows ? 2'd2 : 2'd1,
                                2'd1 + {1'b0, has_prev} + {1'b0, has_next});
    flush_acc.last = !has_next;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (step_go) begin
          state_d = item_last_q ? S_LAST : S_IDLE;
        end
      end
      S_LAST: begin
        if (step_go) begin
          state_d = S_FLOAD;
        end
      end
      S_FLOAD: begin
        state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (acc_ready && !has_next) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State outputs: handshake, result request and line-buffer access
  always_comb begin
    in_stall_o = 1'b1;
    acc_valid  = 1'b0;
    acc        = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    ram_we     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        ram_re     = in_valid_i;
        ram_raddr  = c_in[AW-1:0];
      end
      S_READ: begin
        acc_valid = read_emit;
        acc       = read_acc;
        ram_we    = !read_emit || acc_ready;
      end
      S_LAST: begin
        acc_valid = two_rows;
        acc       = last_acc;
        ram_re    = 1'b1;
      end
      S_FLOAD: begin
        ram_re    = two_rows;
        ram_raddr = AW'(1);
      end
      S_FLUSH: begin
        acc_valid = 1'b1;
        acc       = flush_acc;
        ram_re    = acc_ready && (j_p2 < {1'b0, side_n});
        ram_raddr = j_p2[AW-1:0];
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign step_go = !acc_valid || acc_ready;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      image_side_q <= SIDE_RESET;
      row_q        <= '0;
      col_q        <= '0;
      item_row_q   <= '0;
      item_col_q   <= '0;
      item_last_q  <= 1'b0;
      flush_col_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wen_i) begin
        image_side_q <= cfg_wdata_i;
        row_q        <= '0;
        col_q        <= '0;
      end else if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (accept) begin
        item_row_q  <= r_in;
        item_col_q  <= c_in;
        item_last_q <= last_in;
      end
      if (state_q == S_FLOAD) begin
        flush_col_q <= '0;
      end else if ((state_q == S_FLUSH) && acc_ready) begin
        flush_col_q <= flush_col_q + CW'(1);
      end
    end
  end

  // Pixel, window and sweep registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= px_in;
    end
    if ((state_q == S_READ) && step_go) begin
      win_a_q    <= win_b_q;
      win_b_q[0] <= up_rd;
      win_b_q[1] <= mid_rd;
      win_b_q[2] <= px_q;
    end
    if (state_q == S_FLOAD) begin
      fl_cur_q <= cs_rd;
    end else if ((state_q == S_FLUSH) && acc_ready) begin
      fl_prev_q <= fl_cur_q;
      fl_cur_q  <= cs_rd;
    end
  end

  bblur_mean u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_valid_i (acc_valid),
    .acc_i       (acc),
    .acc_ready_o (acc_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .frame_end_o (frame_end_o)
  );

  `ASSERT_NEVER(a_ram_rw_overlap, ram_we && ram_re && (ram_waddr == ram_raddr), "line buffer read and write overlap")
  `ASSERT_PROP(a_flush_in_range, (state_q == S_FLUSH) |-> (flush_col_q < side_n), "sweep column beyond image side")
  `ASSERT_PROP(a_frame_end_idle, (acc_valid && acc_ready && acc.last) |=> (state_q == S_IDLE), "frame end without return to idle")

endmodule

[tb/box_blur_3x3_edge_aware_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core_tb
// Streams square RGB frames through the border-clipped 3x3 box blur and checks
// every averaged pixel against an in-bench model of the line buffers and the
// sliding window. Both handshakes idle at random, one phase holds the output
// long enough to back the block up to its input, and the image side moves
// through tiny, saturated and restarted settings.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_core_tb;
  import bblur_pkg::*;

  localparam int MAX_SIDE      = MAX_SIDE_DEF;
  localparam int FULL_COUNT    = 9;
  localparam int SETTLE_CYCLES = MAX_SIDE + 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_PIXELS = 24;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } blur_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_wen_i;
  logic [SIDE_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [CH_W-1:0]   in_red_i;
  logic [CH_W-1:0]   in_green_i;
  logic [CH_W-1:0]   in_blue_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [CH_W-1:0]   out_red_o;
  logic [CH_W-1:0]   out_green_o;
  logic [CH_W-1:0]   out_blue_o;
  logic              frame_end_o;

  // Model of the blur: side register, line buffers, window and raster position
  logic [SIDE_W-1:0] side_reg;
  pixel_t            upper_row [MAX_SIDE];
  pixel_t            middle_row [MAX_SIDE];
  pixel_t            nbhd [3][3];
  int unsigned       row_pos;
  int unsigned       col_pos;
  blur_t             expected_blur_q [$];

  bit          idle_on;
  bit          hold_req;
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned frames_seen;
  int unsigned side_writes;
  int unsigned mismatch_count;

  box_blur_3x3_edge_aware_core #(
    .MAX_SIDE(MAX_SIDE)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wen_i  (cfg_wen_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o),
    .frame_end_o(frame_end_o)
  );

  // 100 MHz clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Side in use: zero acts as one, anything above the buffer depth saturates
  function automatic int unsigned active_side();
    if (side_reg == '0) return 1;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return side_reg;
  endfunction

  // Divide the channel sums by the neighbour count and queue the result
  function automatic void push_mean(input int unsigned sum_r, input int unsigned sum_g,
                                    input int unsigned sum_b, input int unsigned num,
                                    input bit last);
    blur_t b;
    if (num == 0 || num > FULL_COUNT) num = 1;
    b.red       = CH_W'(sum_r / num);
    b.green     = CH_W'(sum_g / num);
    b.blue      = CH_W'(sum_b / num);
    b.frame_end = last;
    expected_blur_q.push_back(b);
  endfunction

  // Mean centred on window column cj; rw/cw give the newest column's position
  function automatic void window_mean(input int unsigned cj, input int unsigned rw,
                                      input int unsigned cw);
    int unsigned sr;
    int unsigned sg;
    int unsigned sb;
    int unsigned num;
    sr = 0;
    sg = 0;
    sb = 0;
    num = 0;
    for (int unsigned i = 0; i < 3; i++) begin
      if (!(i == 0 && rw < 2)) begin
        for (int unsigned j = cj - 1; j <= cj + 1 && j < 3; j++) begin
          if (cw + j >= 2) begin
            sr += nbhd[i][j].red;
            sg += nbhd[i][j].green;
            sb += nbhd[i][j].blue;
            num++;
          end
        end
      end
    end
    push_mean(sr, sg, sb, num, 1'b0);
  endfunction

  // Mean of one last-row pixel, read back from the two line buffers
  function automatic void last_row_mean(input int unsigned n, input int unsigned col,
                                        input bit last);
    int unsigned sr;
    int unsigned sg;
    int unsigned sb;
    int unsigned num;
    int unsigned lo;
    int unsigned hi;
    sr = 0;
    sg = 0;
    sb = 0;
    num = 0;
    lo = (col == 0) ? 0 : col - 1;
    hi = (col + 1 < n) ? col + 1 : n - 1;
    for (int unsigned c = lo; c <= hi; c++) begin
      sr += middle_row[c].red;
      sg += middle_row[c].green;
      sb += middle_row[c].blue;
      num++;
      if (n >= 2) begin
        sr += upper_row[c].red;
        sg += upper_row[c].green;
        sb += upper_row[c].blue;
        num++;
      end
    end
    push_mean(sr, sg, sb, num, last);
  endfunction

  // Advance the model by one accepted pixel and queue every result it causes
  function automatic void predict_blur(input pixel_t px);
    int unsigned n;
    int unsigned r;
    int unsigned c;
    bit          last;
    n = active_side();
    r = row_pos;
    c = col_pos;
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
    end
    last = (r == n - 1) && (c == n - 1);

    // right-edge pixel two rows up, still held in the window
    if (c == 0 && r >= 2) window_mean(2, r - 1, n - 1);

    for (int i = 0; i < 3; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2]    = upper_row[c];
    nbhd[1][2]    = middle_row[c];
    nbhd[2][2]    = px;
    upper_row[c]  = middle_row[c];
    middle_row[c] = px;

    if (c >= 1 && r >= 1) window_mean(1, r, c);

    if (last) begin
      if (n >= 2) window_mean(2, r, c);
      for (int unsigned j = 0; j < n; j++) last_row_mean(n, j, j == n - 1);
      row_pos = 0;
      col_pos = 0;
    end else if (c + 1 >= n) begin
      row_pos = r + 1;
      col_pos = 0;
    end else begin
      row_pos = r;
      col_pos = c + 1;
    end
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random channels, biased toward the extremes
  function automatic pixel_t rand_pixel();
    logic [2:0][CH_W-1:0] ch;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 7))
        0:       ch[k] = '0;
        1:       ch[k] = '1;
        default: ch[k] = CH_W'($urandom_range(0, 65535));
      endcase
    end
    return pixel_t'(ch);
  endfunction

  // Offer one pixel, hold it until accepted, then maybe drop valid for a while
  task automatic send_pixel(input pixel_t px);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_red_i   <= px.red;
    in_green_i <= px.green;
    in_blue_i  <= px.blue;
    do @(posedge clk_i); while (in_stall_o);
    predict_blur(px);
    pixels_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_frame(input int unsigned count);
    repeat (count) send_pixel(rand_pixel());
  endtask

  // Drop valid, wait for every queued result, then let the block go quiet
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_blur_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the image side while idle; this restarts the frame
  task automatic write_side(input logic [SIDE_W-1:0] value);
    wait_drained();
    cfg_wen_i   <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    side_reg = value;
    row_pos  = 0;
    col_pos  = 0;
    side_writes++;
    cfg_wen_i <= 1'b0;
  endtask

  // Partial frame at the side left by reset
  task automatic test_reset_side();
    idle_on = 1'b0;
    send_frame(MAX_SIDE + 3);
  endtask

  // Sides of one and two, zero acting as one, back-to-back frames
  task automatic test_tiny_sides();
    idle_on = 1'b1;
    write_side(6'd1);
    send_frame(1);
    write_side(6'd0);
    send_frame(2);
    write_side(6'd2);
    send_frame(4);
  endtask

  // Abandon a frame halfway by rewriting the side
  task automatic test_frame_restart();
    idle_on = 1'b0;
    write_side(6'd3);
    send_frame(4);
    write_side(6'd3);
  endtask

  // Full and empty channels, and mixed extremes, in a 3x3 frame
  task automatic test_channel_extremes();
    pixel_t px;
    for (int k = 0; k < 9; k++) begin
      case (k % 3)
        0:       px = '1;
        1:       px = '0;
        default: px = {16'hFFFF, 16'h0000, 16'h5AA5};
      endcase
      send_pixel(px);
    end
  endtask

  // Side above the buffer depth saturates; two rows and the start of a third
  task automatic test_largest_side();
    idle_on = 1'b1;
    write_side(6'd63);
    send_frame(2 * MAX_SIDE + 2);
  endtask

  // Hold the output long while pixels keep coming, so the input stalls
  task automatic test_output_backpressure();
    idle_on = 1'b0;
    write_side(6'd4);
    hold_req = 1'b1;
    send_frame(2 * 16);
  endtask

  // Random sides and content; some frames cut short by the next write
  task automatic test_random_frames();
    int unsigned start;
    int unsigned n;
    int unsigned frames;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1:    n = $urandom_range(1, 2);
        8, 9:    n = $urandom_range(5, 6);
        default: n = $urandom_range(3, 4);
      endcase
      write_side(SIDE_W'(n));
      frames = $urandom_range(1, 2);
      for (int unsigned f = 0; f < frames; f++) begin
        if (f == frames - 1 && n > 1 && $urandom_range(0, 4) == 0)
          send_frame($urandom_range(1, n * n - 1));
        else
          send_frame(n * n);
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold on request
  initial begin : receiver
    int unsigned len;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        len = pick_gap();
        if (len != 0) begin
          out_stall_i <= 1'b1;
          repeat (len) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : blur_checker
    blur_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (frame_end_o) frames_seen++;
      if (expected_blur_q.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d frame_end %0b",
               out_red_o, out_green_o, out_blue_o, frame_end_o);
        mismatch_count++;
      end else begin
        want = expected_blur_q.pop_front();
        if (out_red_o !== want.red) begin
          $error("out_red: expected %0d, actual %0d", want.red, out_red_o);
          mismatch_count++;
        end
        if (out_green_o !== want.green) begin
          $error("out_green: expected %0d, actual %0d", want.green, out_green_o);
          mismatch_count++;
        end
        if (out_blue_o !== want.blue) begin
          $error("out_blue: expected %0d, actual %0d", want.blue, out_blue_o);
          mismatch_count++;
        end
        if (frame_end_o !== want.frame_end) begin
          $error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end_o);
          mismatch_count++;
        end
      end
    end
  end

  // End the run if no handshake or write happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_wen_i || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, expected_blur_q.size());
    $display("box_blur_3x3_edge_aware_core_tb failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni      <= 1'b0;
    cfg_wen_i   <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_red_i    <= '0;
    in_green_i  <= '0;
    in_blue_i   <= '0;
    side_reg = SIDE_RESET;
    row_pos  = 0;
    col_pos  = 0;
    foreach (upper_row[k]) begin
      upper_row[k]  = '0;
      middle_row[k] = '0;
    end
    foreach (nbhd[i, j]) nbhd[i][j] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_side();
    test_tiny_sides();
    test_frame_restart();
    test_channel_extremes();
    test_largest_side();
    test_output_backpressure();
    test_random_frames();
    wait_drained();

    $display("Sent %0d pixels over %0d side writes; checked %0d blurred pixels, %0d frames.",
             pixels_sent, side_writes, results_seen, frames_seen);
    $display("Sides 0 to 63 incl. saturation, aborted frames, random idling, one long hold.");
    if (mismatch_count == 0)
      $display("box_blur_3x3_edge_aware_core_tb passed");
    else
      $display("box_blur_3x3_edge_aware_core_tb failed");
    $finish;
  end

endmodule
